[rtl/core/u8dec_pkg.sv]
// shared types, codes and lead byte helpers for the utf-8 decoder
`timescale 1ns / 1ps

package u8dec_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 31;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned PEND_N  = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_TAIL
	} u8dec_state_t;

	typedef struct packed {
		logic direct;
		logic latch;
		logic flush;
		logic tail;
	} u8dec_cmd_t;

	typedef struct packed {
		logic has_pending;
		logic byte_cont;
		logic flush_last;
		logic out_free;
	} u8dec_status_t;

	function automatic logic [CNT_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
		logic [CNT_W-1:0] len;
		len = 3'd1;
		priority if (b >= 8'hc0 && b <= 8'hdf) len = 3'd2;
		else if (b >= 8'he0 && b <= 8'hef) len = 3'd3;
		else if (b >= 8'hf0 && b <= 8'hf7) len = 3'd4;
		else if (b >= 8'hf8 && b <= 8'hfb) len = 3'd5;
		else if (b >= 8'hfc && b <= 8'hfd) len = 3'd6;
		else len = 3'd1;
		return len;
	endfunction

	function automatic logic [BYTE_W-1:0] lead_mask(input logic [CNT_W-1:0] len);
		logic [BYTE_W-1:0] m;
		unique case (len)
			3'd2:    m = 8'h1f;
			3'd3:    m = 8'h0f;
			3'd4:    m = 8'h07;
			3'd5:    m = 8'h03;
			3'd6:    m = 8'h01;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

[rtl/core/u8dec_ctrl.sv]
// controller state machine for the utf-8 decoder
`timescale 1ns / 1ps

module u8dec_ctrl
	import u8dec_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  u8dec_status_t status,
	output u8dec_cmd_t    cmd
);

	u8dec_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					if (!status.byte_cont && status.has_pending) begin
						cmd.latch = 1'b1;
						state_d   = ST_FLUSH;
					end else begin
						cmd.direct = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush = 1'b1;
					if (status.flush_last) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				if (status.out_free) begin
					cmd.tail = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/u8dec_datapath.sv]
// sequence buffer, value assembly and output register for the utf-8 decoder
`timescale 1ns / 1ps

module u8dec_datapath
	import u8dec_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BYTE_W-1:0]   text_byte,
	input  u8dec_cmd_t          cmd,
	output u8dec_status_t       status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CP_W-1:0]     code_point,
	output logic                passed_raw,
	output logic                last_of_run
);

	logic [BYTE_W-1:0] pend_q [PEND_N];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  exp_len_q;
	logic [CP_W-1:0]   partial_q;
	logic [CNT_W-1:0]  idx_q;
	logic [BYTE_W-1:0] hold_q;

	logic              out_valid_q;
	logic [CP_W-1:0]   cp_q;
	logic              raw_q;
	logic              last_q;

	logic [BYTE_W-1:0] sel_byte;
	logic              sel_cont;
	logic [CNT_W-1:0]  sel_len;
	logic [CP_W-1:0]   accum;
	logic              accum_done;
	logic              hold_nores;
	logic              proc_emit;
	logic [CP_W-1:0]   proc_cp;
	logic              proc_raw;
	logic              proc_open;
	logic              proc_store;
	logic              proc_clear;
	logic              active;

	assign status.has_pending = (count_q != '0);
	assign status.byte_cont   = (text_byte[7:6] == 2'b10);
	assign status.flush_last  = (idx_q == count_q - 3'd1);
	assign status.out_free    = !out_valid_q || out_ready;

	assign active     = cmd.direct || cmd.tail;
	assign sel_byte   = cmd.tail ? hold_q : text_byte;
	assign sel_cont   = (sel_byte[7:6] == 2'b10);
	assign sel_len    = lead_length(sel_byte);
	assign accum      = {partial_q[CP_W-7:0], sel_byte[5:0]};
	assign accum_done = ({1'b0, count_q} + 4'd1) >= {1'b0, exp_len_q};
	assign hold_nores = (hold_q == '0) || (hold_q[7] && lead_length(hold_q) != 3'd1);

	always_comb begin
		proc_emit  = 1'b0;
		proc_cp    = {{(CP_W-BYTE_W){1'b0}}, sel_byte};
		proc_raw   = 1'b1;
		proc_open  = 1'b0;
		proc_store = 1'b0;
		proc_clear = 1'b0;
		if (sel_cont) begin
			if (count_q == '0) begin
				proc_emit = 1'b1;
			end else if (accum_done) begin
				proc_emit  = 1'b1;
				proc_cp    = accum;
				proc_raw   = 1'b0;
				proc_clear = 1'b1;
			end else begin
				proc_store = 1'b1;
			end
		end else if (sel_byte == '0) begin
			proc_emit = 1'b0;
		end else if (!sel_byte[7]) begin
			proc_emit = 1'b1;
			proc_raw  = 1'b0;
		end else if (sel_len == 3'd1) begin
			proc_emit = 1'b1;
		end else begin
			proc_open = 1'b1;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			exp_len_q <= '0;
			partial_q <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.flush) begin
				if (status.flush_last) begin
					idx_q     <= '0;
					count_q   <= '0;
					exp_len_q <= '0;
					partial_q <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end else if (active) begin
				if (proc_clear) begin
					count_q   <= '0;
					exp_len_q <= '0;
					partial_q <= '0;
				end else if (proc_store) begin
					count_q   <= count_q + 3'd1;
					partial_q <= accum;
				end else if (proc_open) begin
					count_q   <= 3'd1;
					exp_len_q <= sel_len;
					partial_q <= {{(CP_W-BYTE_W){1'b0}}, sel_byte & lead_mask(sel_len)};
				end
			end
		end
	end

	// buffered bytes and the byte that broke the sequence
	always_ff @(posedge clk) begin
		if (active && proc_store) begin
			pend_q[count_q] <= sel_byte;
		end else if (active && proc_open) begin
			pend_q[0] <= sel_byte;
		end
		if (cmd.latch) begin
			hold_q <= text_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.flush || (active && proc_emit)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			cp_q   <= {{(CP_W-BYTE_W){1'b0}}, pend_q[idx_q]};
			raw_q  <= 1'b1;
			last_q <= status.flush_last && hold_nores;
		end else if (active && proc_emit) begin
			cp_q   <= proc_cp;
			raw_q  <= proc_raw;
			last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_point  = cp_q;
	assign passed_raw  = raw_q;
	assign last_of_run = last_q;

endmodule

[rtl/core/utf8_to_code_point_decoder_unit.sv]
// top level of the utf-8 to code point decoder
//
// input channel: in_valid / in_ready carry one text_byte per request.
// output channel: out_valid / out_ready carry code_point, passed_raw and
// last_of_run; last_of_run marks the final result caused by one input byte.
// a byte that completes or continues a sequence, or arrives with nothing
// buffered, is taken directly, and its result (if any) appears on the
// output register the cycle after; with no stall the rate is one byte a cycle.
// a byte that breaks an open sequence starts a flush: the controller emits
// the buffered bytes raw, one per cycle while the receiver takes them, then
// handles the breaking byte.
// a zero byte flushes the buffer and gives no result of its own.
// reset clears the sequence state and the output valid flag at once; the
// buffer itself needs no clearing pass.
// when the receiver stalls, the result holds in the output register and
// in_ready drops until the register is free again.
`timescale 1ns / 1ps

module utf8_to_code_point_decoder_unit
	import u8dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] text_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CP_W-1:0]   code_point,
	output logic              passed_raw,
	output logic              last_of_run
);

	u8dec_cmd_t    cmd;
	u8dec_status_t status;

	u8dec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	u8dec_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.passed_raw  (passed_raw),
		.last_of_run (last_of_run)
	);

endmodule

[tb/utf8_decode_checker.sv]
// checker for the utf-8 decoder: predicts code points from accepted requests and compares results
`timescale 1ns / 1ps

module utf8_decode_checker
	import u8dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [BYTE_W-1:0] text_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CP_W-1:0]   code_point,
	input  logic              passed_raw,
	input  logic              last_of_run,
	output int                mismatch_count,
	output int                open_count
);

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            passed_raw;
		logic            last_of_run;
	} cp_result_t;

	cp_result_t        expected_cps[$];
	logic [BYTE_W-1:0] seq_bytes [PEND_N];
	logic [CNT_W-1:0]  seq_count = '0;
	logic [CNT_W-1:0]  seq_len = '0;
	logic [CP_W-1:0]   seq_value = '0;
	cp_result_t        staged;
	bit                have_staged = 1'b0;

	function automatic logic [CNT_W-1:0] seq_length(input logic [BYTE_W-1:0] b);
		casez (b)
			8'b110?????: return 3'd2;
			8'b1110????: return 3'd3;
			8'b11110???: return 3'd4;
			8'b111110??: return 3'd5;
			8'b1111110?: return 3'd6;
			default:     return 3'd1;
		endcase
	endfunction

	// hold back one result so the final one of a request can be marked
	task automatic emit(input logic [CP_W-1:0] cp, input logic raw);
		if (have_staged)
			expected_cps.push_back(staged);
		staged.code_point  = cp;
		staged.passed_raw  = raw;
		staged.last_of_run = 1'b0;
		have_staged = 1'b1;
	endtask

	task automatic flush_seq();
		for (int i = 0; i < seq_count; i++)
			emit(CP_W'(seq_bytes[i]), 1'b1);
		seq_count = '0;
		seq_len   = '0;
		seq_value = '0;
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		logic [CNT_W-1:0] len;
		have_staged = 1'b0;
		if (b[7:6] == 2'b10) begin
			if (seq_count == 0) begin
				emit(CP_W'(b), 1'b1);
			end else begin
				seq_value = {seq_value[CP_W-7:0], b[5:0]};
				if (seq_count + 1 >= seq_len) begin
					emit(seq_value, 1'b0);
					seq_count = '0;
					seq_len   = '0;
					seq_value = '0;
				end else begin
					seq_bytes[seq_count] = b;
					seq_count = seq_count + 1'b1;
				end
			end
		end else begin
			flush_seq();
			len = seq_length(b);
			if (b != 8'h00) begin
				if (!b[7]) begin
					emit(CP_W'(b), 1'b0);
				end else if (len == 3'd1) begin
					emit(CP_W'(b), 1'b1);
				end else begin
					seq_bytes[0] = b;
					seq_count = 3'd1;
					seq_len   = len;
					seq_value = CP_W'(b & (8'hff >> (len + 1)));
				end
			end
		end
		if (have_staged) begin
			staged.last_of_run = 1'b1;
			expected_cps.push_back(staged);
			have_staged = 1'b0;
		end
	endtask

	// results are taken before requests: a request never answers in its own cycle
	always @(posedge clk or negedge arst_n) begin : watch
		cp_result_t want;
		if (!arst_n) begin
			expected_cps.delete();
			seq_count = '0;
			seq_len   = '0;
			seq_value = '0;
			have_staged = 1'b0;
			mismatch_count = 0;
			open_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cps.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: cp %h raw %b last %b",
							code_point, passed_raw, last_of_run);
					mismatch_count++;
				end else begin
					want = expected_cps.pop_front();
					if (want.code_point !== code_point || want.passed_raw !== passed_raw ||
							want.last_of_run !== last_of_run) begin
						if (mismatch_count < 10)
							$display("mismatch: expected cp %h raw %b last %b, got cp %h raw %b last %b",
								want.code_point, want.passed_raw, want.last_of_run,
								code_point, passed_raw, last_of_run);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				decode_byte(text_byte);
			open_count = expected_cps.size();
		end
	end

endmodule

[tb/tb_utf8_to_code_point_decoder_unit.sv]
// testbench top for the utf-8 decoder: drives byte requests, paces the receiver, gives the verdict
`timescale 1ns / 1ps

module tb_utf8_to_code_point_decoder_unit;
	import u8dec_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 500;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] text_byte;
	logic              out_valid;
	logic              out_ready;
	logic [CP_W-1:0]   code_point;
	logic              passed_raw;
	logic              last_of_run;

	int mismatch_count;
	int open_count;
	int cycle_count = 0;
	int sent_count = 0;
	int stall_left = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_req = 1'b0;
	bit rx_hold_seen = 1'b0;
	bit mid_pause_done = 1'b0;

	// edges of the byte range, overlong and longest forms, broken sequences
	logic [BYTE_W-1:0] directed[$] = '{
		8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff,
		8'hc0, 8'h80,
		8'hef, 8'hbf, 8'hbf,
		8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
		8'hfc, 8'h80, 8'h80, 8'h80, 8'h80, 8'h41,
		8'hc3, 8'he2, 8'h82, 8'h00
	};

	always #5 clk = ~clk;

	utf8_to_code_point_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.passed_raw  (passed_raw),
		.last_of_run (last_of_run)
	);

	utf8_decode_checker cp_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.text_byte      (text_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_point     (code_point),
		.passed_raw     (passed_raw),
		.last_of_run    (last_of_run),
		.mismatch_count (mismatch_count),
		.open_count     (open_count)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_utf8_to_code_point_decoder_unit failed");
			$finish;
		end
	end

	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent_count++;
		if ($urandom_range(0, 59) == 0)
			tx_steady = !tx_steady;
	endtask

	// lead byte plus keep - 1 continuations of a len-byte sequence
	task automatic send_char(input int len, input int keep);
		logic [BYTE_W-1:0] lead;
		if (len == 1)
			lead = BYTE_W'($urandom_range(1, 127));
		else
			lead = ~(8'hff >> len) | (BYTE_W'($urandom) & (8'hff >> (len + 1)));
		send_byte(lead);
		for (int i = 1; i < keep; i++)
			send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
	endtask

	// receiver pacing, with one long hold-off on request from the sender
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req && !rx_hold_seen) begin
				rx_hold_seen = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap(rx_steady);
			end
			if ($urandom_range(0, 199) == 0)
				rx_steady = !rx_steady;
		end
	end

	initial begin
		int r;
		int len;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		text_byte = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_byte(directed[i]);
		in_valid <= 1'b0;
		@(negedge clk);
		while (open_count != 0)
			@(negedge clk);

		while (sent_count < directed.size() + RANDOM_ITEMS) begin
			if (sent_count > 200)
				rx_hold_req = 1'b1;
			if (!mid_pause_done && sent_count > 380) begin
				mid_pause_done = 1'b1;
				in_valid <= 1'b0;
				@(negedge clk);
				while (open_count != 0)
					@(negedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : $urandom_range(4, 6);
				send_char(len, len);
			end else if (r < 80) begin
				len = $urandom_range(2, 6);
				send_char(len, $urandom_range(1, len - 1));
			end else if (r < 90) begin
				send_byte(BYTE_W'($urandom));
			end else if (r < 94) begin
				send_byte(8'h00);
			end else if (r < 97) begin
				send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
			end else begin
				send_byte(8'hfe | BYTE_W'($urandom_range(0, 1)));
			end
		end
		send_byte(8'h00);
		in_valid <= 1'b0;

		while (open_count != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && open_count == 0)
			$display("tb_utf8_to_code_point_decoder_unit passed");
		else
			$display("tb_utf8_to_code_point_decoder_unit failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_ctrl.sv
rtl/core/u8dec_datapath.sv
rtl/core/utf8_to_code_point_decoder_unit.sv
tb/utf8_decode_checker.sv
tb/tb_utf8_to_code_point_decoder_unit.sv
